@@ rtl/core/fsdp_pkg.sv @@
// Package: constants, handshake structs and FSM type for the FFT size planner.
`default_nettype none
package fsdp_pkg;
	localparam int SIZE_LOG2_MAX = 24;
	localparam int BASE_MAX      = 256;
	localparam int SIZE_W        = 25;
	localparam int BASE_W        = 9;
	localparam int SQ_W          = 17;
	localparam int SQ2_W         = 33;
	localparam int CAND_W        = 13;
	localparam int CC_W          = 2 * CAND_W;
	localparam int DVS_W         = 13;
	localparam int DIV_STEPS     = SIZE_W;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
	localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << SIZE_LOG2_MAX;

	typedef struct packed {
		logic              go;
		logic [SIZE_W-1:0] dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] quo;
		logic [DVS_W-1:0]  rem;
	} div_rsp_t;

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_START     = 11'b000_0000_0010,
		S_CLASS     = 11'b000_0000_0100,
		S_SPL_ISSUE = 11'b000_0000_1000,
		S_SPL_WAIT  = 11'b000_0001_0000,
		S_SQ2       = 11'b000_0010_0000,
		S_L2_GATE   = 11'b000_0100_0000,
		S_L2_SQ     = 11'b000_1000_0000,
		S_L2_TEST   = 11'b001_0000_0000,
		S_L2_WAIT   = 11'b010_0000_0000,
		S_R_CHK     = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		CTX_L1 = 2'd0,
		CTX_C  = 2'd1,
		CTX_R  = 2'd2
	} ctx_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_W'(2))
			r = BASE_W'(2);
		else if (b > BASE_W'(BASE_MAX))
			r = BASE_W'(BASE_MAX);
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/fsdp_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module fsdp_div (
	input  wire                clk,
	input  wire                arst_n,
	input  fsdp_pkg::div_req_t req,
	output fsdp_pkg::div_rsp_t rsp
);
	import fsdp_pkg::*;

	logic [SIZE_W-1:0]    dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       rem_sh;
	logic [DVS_W:0]       diff;
	logic                 ge;

	assign rem_sh = {rem_q, dvd_q[SIZE_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SIZE_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

@@ rtl/core/fft_size_decomposition_planner.sv @@
// Top level: FFT size planner sequencer around a shared divider.
//
// Usage: write base_points on the cfg channel (cfg_valid/cfg_ready, always ready)
// while the block is idle; it resets to 16 and is clamped to 2..256 internally.
// Pulse start with xform_len while busy is low; the item is taken at that edge
// and busy stays high until the plan is out. The plan appears on the result
// ports for one cycle with done high; the receiver cannot stall, so it must
// capture it then. One item at a time.
// Search: out-of-range and native sizes finish in the classify state. Each
// divisor trial uses the shared divider; a level-1 search tries divisors from
// the clamped base_points downward, at most to 1. The level-2 search tries
// candidates c = 1, 2, ... with c*c <= size (up to 4096), each with one
// divider trial plus, for a candidate that divides, up to two more level-1 searches.
// Reset: returns to idle, drops done and busy, and loads base_points with 16.
`default_nettype none
module fft_size_decomposition_planner (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [fsdp_pkg::BASE_W-1:0]  cfg_data,
	input  wire                          start,
	output logic                         busy,
	input  wire  [fsdp_pkg::SIZE_W-1:0]  xform_len,
	output logic                         done,
	output logic                         plan_valid,
	output logic [1:0]                   plan_level,
	output logic [16:0]                  row_count,
	output logic [16:0]                  column_count,
	output logic [1:0]                   sub_count,
	output logic [8:0]                   first_sub_factor,
	output logic [8:0]                   first_sub_cofactor,
	output logic [8:0]                   second_sub_factor,
	output logic [8:0]                   second_sub_cofactor
);
	import fsdp_pkg::*;

	state_t            state_q;
	ctx_t              ctx_q;
	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [BASE_W-1:0] bc_q;
	logic [SQ_W-1:0]   sq_q;
	logic [SQ2_W-1:0]  sq2_q;
	logic [CAND_W-1:0] c_q;
	logic [CC_W-1:0]   cc_q;
	logic [SIZE_W-1:0] r_q;
	logic [SQ_W-1:0]   f_q;
	logic [BASE_W-1:0] d_q;
	logic [BASE_W-1:0] cd_q;
	logic [BASE_W-1:0] cq_q;
	logic              done_q;
	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              c_big;
	logic              spl_hit;
	logic              c_ok;

	fsdp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign c_big   = {4'b0, c_q} > {4'b0, bc_q};
	assign spl_hit = drsp.rem == '0 && drsp.quo <= SIZE_W'(bc_q);
	assign c_ok    = drsp.rem == '0 && SQ_W'(c_q) <= sq_q && drsp.quo <= SIZE_W'(sq_q);

	always_comb begin
		dreq.go       = 1'b0;
		dreq.dividend = SIZE_W'(f_q);
		dreq.divisor  = DVS_W'(d_q);
		if (state_q == S_SPL_ISSUE) begin
			dreq.go = 1'b1;
		end else if (state_q == S_L2_TEST) begin
			dreq.go       = !(cc_q > CC_W'(size_q));
			dreq.dividend = size_q;
			dreq.divisor  = c_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = state_q != S_IDLE;
	assign done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_START;
				end
				S_START: state_q <= S_CLASS;
				S_CLASS: begin
					if (size_q > SIZE_LIMIT || size_q <= SIZE_W'(bc_q)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (size_q <= SIZE_W'(sq_q)) begin
						state_q <= S_SPL_ISSUE;
					end else begin
						state_q <= S_SQ2;
					end
				end
				S_SPL_ISSUE: state_q <= S_SPL_WAIT;
				S_SPL_WAIT: begin
					if (drsp.done) begin
						if (spl_hit) begin
							if (ctx_q == CTX_C) begin
								state_q <= S_R_CHK;
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end else if (d_q == BASE_W'(1)) begin
							state_q <= (ctx_q == CTX_L1) ? S_SQ2 : S_L2_SQ;
						end else begin
							state_q <= S_SPL_ISSUE;
						end
					end
				end
				S_SQ2: state_q <= S_L2_GATE;
				S_L2_GATE: begin
					if (SQ2_W'(size_q) > sq2_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_L2_SQ;
					end
				end
				S_L2_SQ: state_q <= S_L2_TEST;
				S_L2_TEST: begin
					if (cc_q > CC_W'(size_q)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_L2_WAIT;
					end
				end
				S_L2_WAIT: begin
					if (drsp.done) begin
						if (!c_ok)
							state_q <= S_L2_SQ;
						else if (c_big)
							state_q <= S_SPL_ISSUE;
						else
							state_q <= S_R_CHK;
					end
				end
				S_R_CHK: begin
					if (r_q <= SIZE_W'(bc_q)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_SPL_ISSUE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					size_q <= xform_len;
					bc_q   <= clamp_base(base_q);
				end
			end
			S_START: begin
				sq_q                <= SQ_W'(bc_q) * SQ_W'(bc_q);
				plan_valid          <= 1'b0;
				plan_level          <= 2'd0;
				row_count           <= '0;
				column_count        <= '0;
				sub_count           <= 2'd0;
				first_sub_factor    <= '0;
				first_sub_cofactor  <= '0;
				second_sub_factor   <= '0;
				second_sub_cofactor <= '0;
			end
			S_CLASS: begin
				if (size_q <= SIZE_LIMIT && size_q <= SIZE_W'(bc_q))
					plan_valid <= 1'b1;
				f_q   <= size_q[SQ_W-1:0];
				d_q   <= bc_q;
				ctx_q <= CTX_L1;
			end
			S_SPL_WAIT: begin
				if (drsp.done) begin
					if (spl_hit) begin
						unique case (ctx_q)
							CTX_L1: begin
								plan_valid   <= 1'b1;
								plan_level   <= 2'd1;
								row_count    <= drsp.quo[16:0];
								column_count <= 17'(d_q);
							end
							CTX_C: begin
								cd_q <= d_q;
								cq_q <= drsp.quo[8:0];
							end
							CTX_R: begin
								plan_valid   <= 1'b1;
								plan_level   <= 2'd2;
								row_count    <= r_q[16:0];
								column_count <= 17'(c_q);
								if (c_big) begin
									sub_count           <= 2'd2;
									first_sub_factor    <= cd_q;
									first_sub_cofactor  <= cq_q;
									second_sub_factor   <= d_q;
									second_sub_cofactor <= drsp.quo[8:0];
								end else begin
									sub_count          <= 2'd1;
									first_sub_factor   <= d_q;
									first_sub_cofactor <= drsp.quo[8:0];
								end
							end
							default: ;
						endcase
					end else if (d_q == BASE_W'(1)) begin
						if (ctx_q != CTX_L1)
							c_q <= c_q + CAND_W'(1);
					end else begin
						d_q <= d_q - BASE_W'(1);
					end
				end
			end
			S_SQ2: begin
				sq2_q <= SQ2_W'(sq_q) * SQ2_W'(sq_q);
				c_q   <= CAND_W'(1);
			end
			S_L2_SQ: cc_q <= CC_W'(c_q) * CC_W'(c_q);
			S_L2_WAIT: begin
				if (drsp.done) begin
					r_q <= drsp.quo;
					if (!c_ok) begin
						c_q <= c_q + CAND_W'(1);
					end else begin
						f_q   <= SQ_W'(c_q);
						d_q   <= bc_q;
						ctx_q <= CTX_C;
					end
				end
			end
			S_R_CHK: begin
				if (r_q <= SIZE_W'(bc_q)) begin
					plan_valid   <= 1'b1;
					plan_level   <= 2'd2;
					row_count    <= r_q[16:0];
					column_count <= 17'(c_q);
				end else begin
					f_q   <= r_q[SQ_W-1:0];
					d_q   <= bc_q;
					ctx_q <= CTX_R;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken without going busy");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !plan_valid |-> plan_level == 2'd0 && sub_count == 2'd0
			&& row_count == '0 && column_count == '0)
		else $error("invalid plan with nonzero fields");
	a_level0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && plan_valid && plan_level == 2'd0 |-> row_count == '0
			&& column_count == '0 && sub_count == 2'd0)
		else $error("native plan with split fields");
`endif
endmodule
`default_nettype wire
